@@ src/fswl_pkg.sv @@
package fswl_pkg;

   // default geometry of the modelled flash page
   localparam int SLOT_COUNT_DEFAULT = 8;
   localparam int SLOT_BYTES_DEFAULT = 128;

   // value of an erased flash byte
   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   // operation codes of a request
   typedef enum logic [1:0] {
      FUNC_CACHE_WRITE = 2'd0,
      FUNC_CACHE_READ  = 2'd1,
      FUNC_COMMIT      = 2'd2,
      FUNC_RECOVER     = 2'd3
   } func_type;

   // page store controls for one cycle
   typedef struct packed {
      logic write;   // program one byte
      logic erase;   // erase whole page
      logic mark;    // slot now holds a record
   } page_ctl_type;

endpackage

@@ src/fswl_page.sv @@
module fswl_page #(
   parameter int SLOT_COUNT = fswl_pkg::SLOT_COUNT_DEFAULT,
   parameter int SLOT_BYTES = fswl_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  fswl_pkg::page_ctl_type                        ctl,
   input  logic [$clog2(SLOT_COUNT*SLOT_BYTES)-1:0]      write_addr,
   input  logic [7:0]                                    write_data,
   input  logic [$clog2(SLOT_COUNT)-1:0]                 mark_slot,
   input  logic [$clog2(SLOT_COUNT*SLOT_BYTES)-1:0]      read_addr,
   output logic [7:0]                                    read_data,
   output logic [SLOT_COUNT-1:0]                         slot_valid
);
   import fswl_pkg::*;

   localparam int PAGE_BYTES = SLOT_COUNT * SLOT_BYTES;

   logic [7:0]            page_mem [PAGE_BYTES];
   logic [7:0]            read_data_ff;
   logic [SLOT_COUNT-1:0] slot_valid_ff;

   // byte array, one program port and one registered read port
   always_ff @(posedge clock) begin
      if (ctl.write) begin
         page_mem[write_addr] <= write_data;
      end
      read_data_ff <= page_mem[read_addr];
   end

   // per-slot valid flags; erase clears every slot at once
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (ctl.erase) begin
         slot_valid_ff <= '0;
      end else if (ctl.mark) begin
         slot_valid_ff[mark_slot] <= 1'b1;
      end
   end

   assign read_data  = read_data_ff;
   assign slot_valid = slot_valid_ff;

endmodule

@@ src/flash_slot_wear_leveler_top.sv @@
// channel    | ports                                   | transfer
// -----------+-----------------------------------------+----------------------------------
// request    | start, busy, req_func, req_byte_index,  | start high while busy is low
//            | req_byte_value                          |
// response   | rsp_strobe, rsp_read_data,              | one cycle wide strobe, no stall
//            | rsp_slot_number, rsp_record_found,      |
//            | rsp_page_erased                         |
//
// cache write answers in the cycle after the request; cache read passes the registered
// cache read and the S_READ state first. commit walks the data bytes of the cache once
// through an xor checksum, then writes the two header bytes. recover copies non-blank
// slots byte by byte into the cache, from the top slot down, until one passes the
// header check. synchronous reset; the page and cache come up erased and zero through
// per-slot and per-byte valid flags, so no clearing pass. the receiver cannot stall.
module flash_slot_wear_leveler_top #(
   parameter int SLOT_COUNT = fswl_pkg::SLOT_COUNT_DEFAULT,
   parameter int SLOT_BYTES = fswl_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [6:0] req_byte_index,
   input  logic [7:0] req_byte_value,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_data,
   output logic [3:0] rsp_slot_number,
   output logic       rsp_record_found,
   output logic       rsp_page_erased
);
   import fswl_pkg::*;

   localparam int CW = $clog2(SLOT_BYTES);
   localparam int SW = $clog2(SLOT_COUNT);
   localparam int PW = $clog2(SLOT_COUNT * SLOT_BYTES);

   localparam logic [CW-1:0] FIRST_BYTE = CW'(0);
   localparam logic [CW-1:0] CHECK_BYTE = CW'(1);
   localparam logic [CW-1:0] DATA_BYTE  = CW'(2);
   localparam logic [CW-1:0] LAST_BYTE  = CW'(SLOT_BYTES - 1);
   localparam logic [SW-1:0] TOP_SLOT   = SW'(SLOT_COUNT - 1);
   localparam logic [SW-1:0] SLOT_ZERO  = SW'(0);
   localparam logic [3:0]    NO_SLOT    = 4'(SLOT_COUNT);
   localparam logic [8:0]    CACHE_SIZE = 9'(SLOT_BYTES);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_CPASS,
      S_CHEAD0,
      S_CHEAD1,
      S_RSCAN,
      S_RPASS,
      S_RCHECK
   } state_type;

   state_type     state_ff, state_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] dst_ff, dst_in;
   logic          pend_ff, pend_in;
   logic          issued_ff, issued_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    hdr0_ff, hdr0_in;
   logic [7:0]    hdr1_ff, hdr1_in;
   logic          erased_ff, erased_in;

   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]    rsp_read_data_ff, rsp_read_data_in;
   logic [3:0]    rsp_slot_number_ff, rsp_slot_number_in;
   logic          rsp_record_found_ff, rsp_record_found_in;
   logic          rsp_page_erased_ff, rsp_page_erased_in;

   // record cache
   logic [7:0]            cache_mem [SLOT_BYTES];
   logic [SLOT_BYTES-1:0] cache_valid_ff;
   logic [7:0]            cache_rd_ff;
   logic                  cache_rd_ok_ff;
   logic [CW-1:0]         cache_raddr;
   logic                  cache_we;
   logic [CW-1:0]         cache_waddr;
   logic [7:0]            cache_wdata;
   logic [7:0]            cache_q;

   // page store
   page_ctl_type          page_ctl;
   logic [PW-1:0]         page_base;
   logic [PW-1:0]         page_waddr;
   logic [7:0]            page_wdata;
   logic [PW-1:0]         page_raddr;
   logic [7:0]            page_q;
   logic [SLOT_COUNT-1:0] slot_valid;

   // request decode
   logic          accept;
   logic [8:0]    req_index_wide;
   logic          req_in_range;
   logic [CW-1:0] req_cache_idx;
   logic [SW-1:0] free_slot;
   logic          free_found;
   logic          check_match;

   fswl_page #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_page (
      .clock      (clock),
      .reset      (reset),
      .ctl        (page_ctl),
      .write_addr (page_waddr),
      .write_data (page_wdata),
      .mark_slot  (slot_ff),
      .read_addr  (page_raddr),
      .read_data  (page_q),
      .slot_valid (slot_valid)
   );

   assign busy           = (state_ff != S_IDLE);
   assign accept         = start && !busy;
   assign req_index_wide = {2'b00, req_byte_index};
   assign req_in_range   = (req_index_wide < CACHE_SIZE);
   assign req_cache_idx  = req_index_wide[CW-1:0];

   // never-written cache bytes read as zero
   assign cache_q = cache_rd_ok_ff ? cache_rd_ff : 8'h00;

   // byte address within the page for the current slot
   assign page_base  = PW'(slot_ff) * PW'(SLOT_BYTES);
   assign page_raddr = page_base + PW'(cnt_ff);

   assign check_match = (hdr0_ff == 8'(slot_ff)) && (sum_ff == hdr1_ff);

   // lowest blank slot
   always_comb begin
      free_slot  = SLOT_ZERO;
      free_found = 1'b0;
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (!slot_valid[s]) begin
            free_slot  = SW'(s);
            free_found = 1'b1;
         end
      end
   end

   // sequencer for cache access, commit and recover
   always_comb begin
      state_in            = state_ff;
      slot_in             = slot_ff;
      cnt_in              = cnt_ff;
      dst_in              = dst_ff;
      pend_in             = pend_ff;
      issued_in           = issued_ff;
      sum_in              = sum_ff;
      hdr0_in             = hdr0_ff;
      hdr1_in             = hdr1_ff;
      erased_in           = erased_ff;
      rsp_strobe_in       = 1'b0;
      rsp_read_data_in    = rsp_read_data_ff;
      rsp_slot_number_in  = rsp_slot_number_ff;
      rsp_record_found_in = rsp_record_found_ff;
      rsp_page_erased_in  = rsp_page_erased_ff;

      cache_raddr = cnt_ff;
      cache_we    = 1'b0;
      cache_waddr = dst_ff;
      cache_wdata = page_q;
      page_ctl    = '0;
      page_waddr  = page_base + PW'(dst_ff);
      page_wdata  = cache_q;

      case (state_ff)
         S_IDLE: begin
            cache_raddr = req_cache_idx;
            if (accept) begin
               case (func_type'(req_func))
                  FUNC_CACHE_WRITE: begin
                     cache_we            = req_in_range;
                     cache_waddr         = req_cache_idx;
                     cache_wdata         = req_byte_value;
                     rsp_strobe_in       = 1'b1;
                     rsp_read_data_in    = 8'h00;
                     rsp_slot_number_in  = 4'h0;
                     rsp_record_found_in = 1'b0;
                     rsp_page_erased_in  = 1'b0;
                  end
                  FUNC_CACHE_READ: begin
                     erased_in = req_in_range;
                     state_in  = S_READ;
                  end
                  FUNC_COMMIT: begin
                     // erase when the page is full, then use slot 0
                     page_ctl.erase = !free_found;
                     erased_in      = !free_found;
                     slot_in        = free_slot;
                     cnt_in         = DATA_BYTE;
                     pend_in        = 1'b0;
                     issued_in      = 1'b0;
                     sum_in         = 8'h00;
                     state_in       = S_CPASS;
                  end
                  FUNC_RECOVER: begin
                     slot_in  = TOP_SLOT;
                     state_in = S_RSCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_READ: begin
            // erased_ff holds the range check of the read here
            rsp_strobe_in       = 1'b1;
            rsp_read_data_in    = erased_ff ? cache_q : 8'h00;
            rsp_slot_number_in  = 4'h0;
            rsp_record_found_in = 1'b0;
            rsp_page_erased_in  = 1'b0;
            state_in            = S_IDLE;
         end

         S_CPASS: begin
            // issue cache reads for the data bytes
            if (!issued_ff) begin
               pend_in   = 1'b1;
               dst_in    = cnt_ff;
               cnt_in    = cnt_ff + CW'(1);
               issued_in = (cnt_ff == LAST_BYTE);
            end else begin
               pend_in = 1'b0;
            end
            // program the byte read last cycle and fold it into the checksum
            if (pend_ff) begin
               page_ctl.write = 1'b1;
               sum_in         = sum_ff ^ cache_q;
            end
            if (issued_ff && !pend_ff) begin
               state_in = S_CHEAD0;
            end
         end

         S_CHEAD0: begin
            page_ctl.write = 1'b1;
            page_waddr     = page_base + PW'(FIRST_BYTE);
            page_wdata     = 8'(slot_ff);
            cache_we       = 1'b1;
            cache_waddr    = FIRST_BYTE;
            cache_wdata    = 8'(slot_ff);
            state_in       = S_CHEAD1;
         end

         S_CHEAD1: begin
            page_ctl.write      = 1'b1;
            page_ctl.mark       = 1'b1;
            page_waddr          = page_base + PW'(CHECK_BYTE);
            page_wdata          = sum_ff;
            cache_we            = 1'b1;
            cache_waddr         = CHECK_BYTE;
            cache_wdata         = sum_ff;
            rsp_strobe_in       = 1'b1;
            rsp_read_data_in    = 8'h00;
            rsp_slot_number_in  = 4'(slot_ff);
            rsp_record_found_in = 1'b0;
            rsp_page_erased_in  = erased_ff;
            state_in            = S_IDLE;
         end

         S_RSCAN: begin
            if (slot_valid[slot_ff]) begin
               cnt_in    = FIRST_BYTE;
               pend_in   = 1'b0;
               issued_in = 1'b0;
               sum_in    = 8'h00;
               state_in  = S_RPASS;
            end else if (slot_ff == SLOT_ZERO) begin
               rsp_strobe_in       = 1'b1;
               rsp_read_data_in    = 8'h00;
               rsp_slot_number_in  = NO_SLOT;
               rsp_record_found_in = 1'b0;
               rsp_page_erased_in  = 1'b0;
               state_in            = S_IDLE;
            end else begin
               slot_in = slot_ff - SW'(1);
            end
         end

         S_RPASS: begin
            // issue page reads for every byte of the slot
            if (!issued_ff) begin
               pend_in   = 1'b1;
               dst_in    = cnt_ff;
               cnt_in    = cnt_ff + CW'(1);
               issued_in = (cnt_ff == LAST_BYTE);
            end else begin
               pend_in = 1'b0;
            end
            // copy into the cache, keep the header, sum the data bytes
            if (pend_ff) begin
               cache_we = 1'b1;
               if (dst_ff == FIRST_BYTE) begin
                  hdr0_in = page_q;
               end else if (dst_ff == CHECK_BYTE) begin
                  hdr1_in = page_q;
               end else begin
                  sum_in = sum_ff ^ page_q;
               end
            end
            if (issued_ff && !pend_ff) begin
               state_in = S_RCHECK;
            end
         end

         S_RCHECK: begin
            if (check_match) begin
               rsp_strobe_in       = 1'b1;
               rsp_read_data_in    = 8'h00;
               rsp_slot_number_in  = 4'(slot_ff);
               rsp_record_found_in = 1'b1;
               rsp_page_erased_in  = 1'b0;
               state_in            = S_IDLE;
            end else if (slot_ff == SLOT_ZERO) begin
               rsp_strobe_in       = 1'b1;
               rsp_read_data_in    = 8'h00;
               rsp_slot_number_in  = NO_SLOT;
               rsp_record_found_in = 1'b0;
               rsp_page_erased_in  = 1'b0;
               state_in            = S_IDLE;
            end else begin
               slot_in  = slot_ff - SW'(1);
               state_in = S_RSCAN;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         issued_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         issued_ff     <= issued_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      slot_ff             <= slot_in;
      cnt_ff              <= cnt_in;
      dst_ff              <= dst_in;
      sum_ff              <= sum_in;
      hdr0_ff             <= hdr0_in;
      hdr1_ff             <= hdr1_in;
      erased_ff           <= erased_in;
      rsp_read_data_ff    <= rsp_read_data_in;
      rsp_slot_number_ff  <= rsp_slot_number_in;
      rsp_record_found_ff <= rsp_record_found_in;
      rsp_page_erased_ff  <= rsp_page_erased_in;
   end

   // cache array with registered read
   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_waddr] <= cache_wdata;
      end
      cache_rd_ff <= cache_mem[cache_raddr];
   end

   // per-byte written flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_valid_ff <= '0;
         cache_rd_ok_ff <= 1'b0;
      end else begin
         if (cache_we) begin
            cache_valid_ff[cache_waddr] <= 1'b1;
         end
         cache_rd_ok_ff <= cache_valid_ff[cache_raddr];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_slot_number  = rsp_slot_number_ff;
   assign rsp_record_found = rsp_record_found_ff;
   assign rsp_page_erased  = rsp_page_erased_ff;

endmodule
